@@ rtl/lcd_nibble_bus_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef LCD_NIBBLE_BUS_SEQUENCER_ASSERT_SVH
`define LCD_NIBBLE_BUS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LNBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lnbs_pkg.sv @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnbs_pkg;

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned DELAY_W  = 16;
   localparam int unsigned LAP_W    = 3;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned TIMER_W  = 17;
   localparam int unsigned CSR_IDX_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_CMD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ACCEPT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REFUSE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DONE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY     = 2'd3;

   // Register reset values
   localparam logic                 BACKLIGHT_RST = 1'b1;
   localparam logic [DELAY_W-1:0]   ENABLE_RST    = 16'd1;
   localparam logic [DELAY_W-1:0]   SETTLE_RST    = 16'd50;
   localparam logic [DELAY_W-1:0]   RETRY_RST     = 16'd100;

   // Expander byte masks
   localparam logic [DATA_W-1:0] NIBBLE_HI_MASK = 8'hF0;
   localparam logic [DATA_W-1:0] BIT_EN         = 8'h04;

   typedef enum logic [1:0] {
      PH_READY   = 2'd0,
      PH_TIMEOUT = 2'd1,
      PH_SENDING = 2'd2,
      PH_RETRY   = 2'd3
   } phase_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE  = 2'd0,
      ACT_SEND  = 2'd1,
      ACT_TIMER = 2'd2,
      ACT_READY = 2'd3
   } action_type;

   typedef struct packed {
      logic                 backlight_on;
      logic [DELAY_W-1:0]   enable_delay;
      logic [DELAY_W-1:0]   settle_delay;
      logic [DELAY_W-1:0]   retry_delay;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [DATA_W-1:0]    cmd_data;
      logic [DELAY_W-1:0]   cmd_delay;
      logic                 cmd_rs;
      logic [LAP_W-1:0]     cmd_laps;
   } item_type;

   typedef struct packed {
      phase_type            phase;
      logic [LAP_W-1:0]     lap;
      logic [DATA_W-1:0]    shadow_byte;
      logic [TIMER_W-1:0]   pending_wait;
      logic [DATA_W-1:0]    held_data;
      logic [DELAY_W-1:0]   held_delay;
   } seq_state_type;

   typedef struct packed {
      action_type           action;
      logic [DATA_W-1:0]    bus_byte;
      logic [TIMER_W-1:0]   timer_value;
      logic                 dropped;
   } result_type;

endpackage

@@ rtl/lnbs_if.sv @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lnbs_req_if
   import lnbs_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [DATA_W-1:0]    cmd_data;
   logic [DELAY_W-1:0]   cmd_delay;
   logic                 cmd_rs;
   logic [LAP_W-1:0]     cmd_laps;

   modport source (output valid, mode, cmd_data, cmd_delay, cmd_rs, cmd_laps,
                   input ready);
   modport sink   (input valid, mode, cmd_data, cmd_delay, cmd_rs, cmd_laps,
                   output ready);
endinterface

interface lnbs_rsp_if
   import lnbs_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [DATA_W-1:0]    bus_byte;
   logic [TIMER_W-1:0]   timer_value;
   logic                 dropped;

   modport source (output valid, action, bus_byte, timer_value, dropped,
                   input ready);
   modport sink   (input valid, action, bus_byte, timer_value, dropped,
                   output ready);
endinterface

@@ rtl/lnbs_csr.sv @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer configuration registers
// Write-only register file for backlight and timing values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnbs_csr
   import lnbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DELAY_W-1:0]    csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BACKLIGHT: cfg_in.backlight_on = csr_wdata[0];
            CSR_ENABLE:    cfg_in.enable_delay = csr_wdata;
            CSR_SETTLE:    cfg_in.settle_delay = csr_wdata;
            CSR_RETRY:     cfg_in.retry_delay  = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backlight_on <= BACKLIGHT_RST;
         cfg_ff.enable_delay <= ENABLE_RST;
         cfg_ff.settle_delay <= SETTLE_RST;
         cfg_ff.retry_delay  <= RETRY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/lnbs_step.sv @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer step logic
// Decides the result and next sequencer state for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnbs_step
   import lnbs_pkg::*;
(
   input  item_type       item,
   input  seq_state_type  cur,
   input  cfg_type        cfg,
   output seq_state_type  nxt,
   output result_type     res
);

   // Build the expander byte and wait for the lap held in s.lap.
   function automatic seq_state_type prepare_lap(seq_state_type s, cfg_type c);
      seq_state_type t;
      t = s;
      case (s.lap) inside
         3'd5: begin
            t.shadow_byte  = s.shadow_byte | (s.held_data & NIBBLE_HI_MASK);
            t.pending_wait = '0;
         end
         3'd2: begin
            t.shadow_byte  = {s.held_data[3:0], s.shadow_byte[3:0]};
            t.pending_wait = '0;
         end
         3'd4, 3'd1: begin
            t.shadow_byte  = s.shadow_byte | BIT_EN;
            t.pending_wait = {1'b0, c.enable_delay};
         end
         3'd3: begin
            t.shadow_byte  = s.shadow_byte & ~BIT_EN;
            t.pending_wait = {1'b0, c.settle_delay};
         end
         3'd0: begin
            t.shadow_byte  = s.shadow_byte & ~BIT_EN;
            t.pending_wait = {1'b0, c.settle_delay} + {1'b0, s.held_delay};
         end
         // laps six and seven resend the byte as it stands
         default: t.pending_wait = '0;
      endcase
      t.phase = PH_RETRY;
      return t;
   endfunction

   seq_state_type started;
   seq_state_type stepped;
   logic          empty_cmd;

   assign empty_cmd = (item.cmd_data == '0) && (item.cmd_delay == '0) &&
                      !item.cmd_rs && (item.cmd_laps == '0);

   always_comb begin
      started             = cur;
      started.held_data   = item.cmd_data;
      started.held_delay  = item.cmd_delay;
      started.lap         = item.cmd_laps;
      started.shadow_byte = {4'b0000, cfg.backlight_on, 2'b00, item.cmd_rs};
   end

   always_comb begin
      stepped     = cur;
      stepped.lap = cur.lap - LAP_W'(1);
   end

   always_comb begin
      nxt             = cur;
      res.action      = ACT_NONE;
      res.bus_byte    = '0;
      res.timer_value = '0;
      res.dropped     = 1'b0;
      unique case (item.mode)
         MODE_CMD: begin
            if (cur.phase != PH_READY) begin
               res.dropped = 1'b1;
            end else if (empty_cmd) begin
               res.action = ACT_READY;
            end else if (item.cmd_data == '0) begin
               nxt             = started;
               nxt.lap         = '0;
               nxt.phase       = PH_TIMEOUT;
               res.action      = ACT_TIMER;
               res.timer_value = {1'b0, item.cmd_delay};
            end else begin
               nxt          = prepare_lap(started, cfg);
               res.action   = ACT_SEND;
               res.bus_byte = nxt.shadow_byte;
            end
         end
         MODE_ACCEPT: begin
            if (cur.phase == PH_RETRY) nxt.phase = PH_SENDING;
         end
         MODE_REFUSE: begin
            if (cur.phase == PH_RETRY) begin
               res.action      = ACT_TIMER;
               res.timer_value = {1'b0, cfg.retry_delay};
            end
         end
         MODE_DONE: begin
            if (cur.phase == PH_SENDING) begin
               if (cur.pending_wait != '0) begin
                  nxt.phase       = PH_TIMEOUT;
                  res.action      = ACT_TIMER;
                  res.timer_value = cur.pending_wait;
               end else if (cur.lap == '0) begin
                  nxt.phase  = PH_READY;
                  res.action = ACT_READY;
               end else begin
                  nxt          = prepare_lap(stepped, cfg);
                  res.action   = ACT_SEND;
                  res.bus_byte = nxt.shadow_byte;
               end
            end
         end
         MODE_EXPIRE: begin
            if (cur.phase == PH_RETRY) begin
               res.action   = ACT_SEND;
               res.bus_byte = cur.shadow_byte;
            end else if (cur.phase == PH_TIMEOUT) begin
               if (cur.lap != '0) begin
                  nxt          = prepare_lap(stepped, cfg);
                  res.action   = ACT_SEND;
                  res.bus_byte = nxt.shadow_byte;
               end else begin
                  nxt.phase  = PH_READY;
                  res.action = ACT_READY;
               end
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule

@@ rtl/lcd_nibble_bus_sequencer.sv @@
// ----------------------------------------------------------------------------
// LCD nibble-bus sequencer
// Drives a character LCD in 4-bit mode through an 8-bit bus expander.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Payload
// req_ch    in         valid / ready   mode, cmd_data, cmd_delay, cmd_rs, cmd_laps
// rsp_ch    out        valid / ready   action, bus_byte, timer_value, dropped
// csr_*     in         csr_we          csr_index, csr_wdata (write only)
//
// A request passes through the request register, then one pass of step logic
// into the response register, which also updates state.
// A new request is taken every cycle while the response side keeps up.
// When rsp_ch stalls, the staged request holds and req_ch.ready drops.
// Reset is synchronous; it loads the register defaults and the ready phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lcd_nibble_bus_sequencer_assert.svh"

module lcd_nibble_bus_sequencer
   import lnbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lnbs_req_if.sink              req_ch,
   lnbs_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DELAY_W-1:0]    csr_wdata
);

   cfg_type        cfg;
   item_type       item_ff;
   logic           item_valid_ff;
   logic           item_valid_in;
   seq_state_type  state_ff;
   seq_state_type  state_in;
   seq_state_type  step_nxt;
   result_type     step_res;
   result_type     rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           advance;
   logic           take;

   lnbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lnbs_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   // Move the staged request into the response register when it is free.
   assign advance       = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !item_valid_ff || advance;
   assign take          = req_ch.valid && req_ch.ready;
   assign item_valid_in = take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ch.ready);
   assign state_in      = advance ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{phase: PH_READY, default: '0};
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.mode      <= req_ch.mode;
         item_ff.cmd_data  <= req_ch.cmd_data;
         item_ff.cmd_delay <= req_ch.cmd_delay;
         item_ff.cmd_rs    <= req_ch.cmd_rs;
         item_ff.cmd_laps  <= req_ch.cmd_laps;
      end
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = rsp_ff.action;
   assign rsp_ch.bus_byte    = rsp_ff.bus_byte;
   assign rsp_ch.timer_value = rsp_ff.timer_value;
   assign rsp_ch.dropped     = rsp_ff.dropped;

   `LNBS_ASSERT_IMPLIES(a_ready_lap_zero, clock, reset,
      state_ff.phase == PH_READY, state_ff.lap == '0, "ready phase with nonzero lap")
   `LNBS_ASSERT_IMPLIES(a_no_advance_on_stall, clock, reset,
      rsp_valid_ff && !rsp_ch.ready, !advance, "response overwritten while stalled")
   `LNBS_ASSERT_IMPLIES(a_byte_only_on_send, clock, reset,
      rsp_valid_ff && rsp_ff.action != ACT_SEND, rsp_ff.bus_byte == '0, "stray bus byte")
   `LNBS_ASSERT_IMPLIES(a_timer_only_on_start, clock, reset,
      rsp_valid_ff && rsp_ff.action != ACT_TIMER, rsp_ff.timer_value == '0,
      "stray timer value")
   `LNBS_ASSERT_IMPLIES(a_dropped_no_action, clock, reset,
      rsp_valid_ff && rsp_ff.dropped, rsp_ff.action == ACT_NONE, "dropped with action")
   `LNBS_ASSERT_NEXT(a_state_holds_idle, clock, reset,
      !advance, state_ff == $past(state_ff), "state changed without a request")

endmodule
